### src/btdd_pkg.sv
`timescale 1ns / 1ps

package btdd_pkg;

   localparam int DEF_WIDTH      = 64;
   localparam int DEF_MAX_DIGITS = 19;
   localparam int VALUE_W        = 64;
   localparam int DIGIT_W        = 4;
   localparam int RSP_DATA_W     = 8;

   localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic move;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

### src/binary_to_decimal_digits.sv
`timescale 1ns / 1ps

// Converts one signed integer per request into the decimal digits of its
// magnitude, most significant first, one digit per response beat, with
// tlast on the final digit. Zero gives a single 0 digit; leading zeros are
// never sent. The magnitude is shifted one bit per cycle through a row of
// MAX_DIGITS decimal digit cells; the digits are then shifted out of the
// top cell one per cycle while the response side is not stalled, leading
// zero positions being passed over without a beat. A new request is taken
// only once the last digit of the previous one has been placed in the
// output register.
module binary_to_decimal_digits
   import btdd_pkg::*;
#(
   parameter int WIDTH      = DEF_WIDTH,
   parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // digit, zero fill
   output logic                  rsp_tlast    // last
);

   localparam int CNT_W = $clog2(WIDTH + 1);
   localparam int REM_W = $clog2(MAX_DIGITS + 1);

   state_type           state_ff, state_in;
   logic [WIDTH-1:0]    mag_ff, mag_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic                started_ff, started_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0]  rsp_digit_ff, rsp_digit_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [WIDTH-1:0]    v_raw;
   logic [WIDTH-1:0]    v_neg;
   logic                accept;
   logic                slot_free;
   logic                skip;
   cell_ctl_type        ctl;

   logic [DIGIT_W-1:0]  digit_w [MAX_DIGITS];
   logic [MAX_DIGITS:0] carry_w;
   logic [DIGIT_W-1:0]  top_digit;

   assign v_raw      = req_tdata[WIDTH-1:0];
   assign v_neg      = ~v_raw + {{(WIDTH-1){1'b0}}, 1'b1};
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign carry_w[0] = mag_ff[WIDTH-1];
   assign top_digit  = digit_w[MAX_DIGITS-1];
   assign skip       = !started_ff && (top_digit == '0) && !ovf_ff
                       && (rem_ff != REM_W'(1));

   genvar gi;
   generate
      for (gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
         logic [DIGIT_W-1:0] lower_digit;
         if (gi == 0) begin : g_low
            assign lower_digit = '0;
         end else begin : g_mid
            assign lower_digit = digit_w[gi-1];
         end
         btdd_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .carry_in  (carry_w[gi]),
            .digit_in  (lower_digit),
            .digit_out (digit_w[gi]),
            .carry_out (carry_w[gi+1])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      started_in   = started_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_digit_in = rsp_digit_ff;
      rsp_last_in  = rsp_last_ff;
      ctl          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mag_in    = v_raw[WIDTH-1] ? v_neg : v_raw;
               cnt_in    = CNT_W'(WIDTH);
               ovf_in    = 1'b0;
               ctl.clear = 1'b1;
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            ctl.dabble = 1'b1;
            mag_in     = {mag_ff[WIDTH-2:0], 1'b0};
            cnt_in     = cnt_ff - CNT_W'(1);
            ovf_in     = ovf_ff || carry_w[MAX_DIGITS];
            if (cnt_ff == CNT_W'(1)) begin
               rem_in     = REM_W'(MAX_DIGITS);
               started_in = 1'b0;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               ctl.move = 1'b1;
               rem_in   = rem_ff - REM_W'(1);
               if (!skip) begin
                  rsp_valid_in = 1'b1;
                  rsp_digit_in = top_digit;
                  rsp_last_in  = (rem_ff == REM_W'(1));
                  started_in   = 1'b1;
                  if (rem_ff == REM_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         started_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         started_ff   <= started_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-DIGIT_W){1'b0}}, rsp_digit_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### src/btdd_cell.sv
`timescale 1ns / 1ps

module btdd_cell
   import btdd_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic               carry_in,
   input  logic [DIGIT_W-1:0] digit_in,
   output logic [DIGIT_W-1:0] digit_out,
   output logic               carry_out
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in_nx;
   logic [DIGIT_W-1:0] adj;

   // add three before the doubling so the digit wraps at ten
   always_comb begin
      adj = (digit_ff >= DABBLE_LIMIT) ? digit_ff + DABBLE_ADD : digit_ff;
      carry_out = adj[DIGIT_W-1];
      digit_in_nx = digit_ff;
      if (ctl.clear) begin
         digit_in_nx = '0;
      end else if (ctl.dabble) begin
         digit_in_nx = {adj[DIGIT_W-2:0], carry_in};
      end else if (ctl.move) begin
         digit_in_nx = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_nx;
   end

   assign digit_out = digit_ff;

endmodule

### tb/sv/binary_to_decimal_digits_test.sv
`timescale 1ns / 1ps

module binary_to_decimal_digits_test
   import btdd_pkg::*;
();

   localparam int        WATCHDOG_LIMIT = 4000;
   localparam int        HOLD_CYCLES    = 400;
   localparam int        TAIL_CYCLES    = 100;
   localparam int        PHASE_ITEMS    = 70;
   localparam int        DIR_ROWS       = 18;
   localparam logic [7:0] ASCII_ZERO    = 8'h30;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               last;
   } digit_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata;   // value
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // digit, zero fill
   logic                  rsp_tlast;   // last

   digit_beat_type pending_digits [$];
   int          failures     = 0;
   int          send_idle    = 0;
   int          recv_idle    = 0;
   bit          hold_pending = 0;
   int          quiet_cycles = 0;

   // directed rows; an empty string means the digits come from the predictor
   logic [VALUE_W-1:0] dir_value [DIR_ROWS] = '{
      64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'd99, 64'd100, -64'sd12345,
      64'd1000000000000000000, 64'd999999999999999999, -64'sd1000000000000000000,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_0000_0001
   };
   string dir_digits [DIR_ROWS] = '{
      "0", "1", "1", "9", "10", "10",
      "9223372036854775807", "9223372036854775808",
      "", "", "", "", "", "", "", "", "", ""
   };

   binary_to_decimal_digits u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_decimal_digits(input logic [VALUE_W-1:0] value);
      logic [DEF_WIDTH-1:0] v;
      logic [DEF_WIDTH-1:0] mag;
      logic [DIGIT_W-1:0]   lsd_first [$];
      digit_beat_type       beat;
      v   = value[DEF_WIDTH-1:0];
      mag = v[DEF_WIDTH-1] ? (~v + 1'b1) : v;
      if (mag == 0) begin
         lsd_first = {lsd_first, DIGIT_W'(0)};
      end else begin
         while (mag != 0 && lsd_first.size() < DEF_MAX_DIGITS) begin
            lsd_first = {lsd_first, DIGIT_W'(mag % 64'd10)};
            mag = mag / 64'd10;
         end
      end
      for (int i = lsd_first.size() - 1; i >= 0; i--) begin
         beat.digit = lsd_first[i];
         beat.last  = (i == 0);
         pending_digits = {pending_digits, beat};
      end
   endfunction

   function automatic void push_digit_string(input string s);
      digit_beat_type beat;
      for (int i = 0; i < s.len(); i++) begin
         beat.digit = DIGIT_W'(s[i] - ASCII_ZERO);
         beat.last  = (i == s.len() - 1);
         pending_digits = {pending_digits, beat};
      end
   endfunction

   function automatic logic [VALUE_W-1:0] pow10(input int n);
      logic [VALUE_W-1:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) p = p * 64'd10;
      return p;
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] mag;
      int                 n;
      mag = {$urandom, $urandom};
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            n   = $urandom_range(1, 19);
            mag = mag % pow10(n);
         end
         5, 6, 7: begin
            return mag;
         end
         8: begin
            n = $urandom_range(0, 18);
            case ($urandom_range(4))
               0: return 64'h8000_0000_0000_0000;
               1: return 64'h7FFF_FFFF_FFFF_FFFF;
               2: mag = pow10(n);
               3: mag = pow10(n) - 64'd1;
               default: mag = 64'd0;
            endcase
         end
         default: begin
            mag = 64'($urandom_range(0, 20));
         end
      endcase
      return $urandom_range(1) ? (~mag + 64'd1) : mag;
   endfunction

   task automatic offer_value(input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_digits.size() != 0);
   endtask

   task automatic run_random(input int count);
      logic [VALUE_W-1:0] value;
      for (int i = 0; i < count; i++) begin
         value = random_value();
         offer_value(value);
         push_decimal_digits(value);
         if ($urandom_range(39) == 0) wait_drained();
      end
   endtask

   // receiver, with a single long hold-off when hold_pending is set
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      digit_beat_type exp_beat;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_digits.size() == 0) begin
            $display("%0t: unexpected digit: expected none, actual %0d last %0b",
                     $time, rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            exp_beat = pending_digits.pop_front();
            if (rsp_tdata != RSP_DATA_W'(exp_beat.digit)) begin
               $display("%0t: digit mismatch: expected %0d, actual %0d",
                        $time, exp_beat.digit, rsp_tdata);
               failures++;
            end
            if (rsp_tlast != exp_beat.last) begin
               $display("%0t: last mismatch: expected %0b, actual %0b",
                        $time, exp_beat.last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("binary_to_decimal_digits test failed");
            $finish;
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle = 29;
      recv_idle = 78;
      for (int r = 0; r < DIR_ROWS; r++) begin
         offer_value(dir_value[r]);
         if (dir_digits[r].len() != 0) push_digit_string(dir_digits[r]);
         else push_decimal_digits(dir_value[r]);
      end
      run_random(PHASE_ITEMS);
      wait_drained();

      send_idle = 78;
      recv_idle = 29;
      run_random(PHASE_ITEMS);
      wait_drained();

      // long receiver hold-off with the sender streaming
      send_idle    = 0;
      recv_idle    = 0;
      hold_pending = 1'b1;
      run_random(PHASE_ITEMS);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && pending_digits.size() == 0) begin
         $display("binary_to_decimal_digits test passed");
      end else begin
         $display("binary_to_decimal_digits test failed");
      end
      $finish;
   end

endmodule

### sim.f
src/btdd_pkg.sv
src/btdd_cell.sv
src/binary_to_decimal_digits.sv
tb/sv/binary_to_decimal_digits_test.sv
